// File: sv/lcsc_pkg.sv
// ----------------------------------------------------------------------------
// lcsc_pkg - level crossing sequence controller package
// Shared codes, state record and sensor sample record.
// ----------------------------------------------------------------------------
`default_nettype none

package lcsc_pkg;

   typedef enum logic [1:0] {
      DIR_NONE         = 2'd0,
      DIR_EAST_TO_WEST = 2'd1,
      DIR_WEST_TO_EAST = 2'd2
   } direction_type;

   typedef enum logic [2:0] {
      MODE_IDLE         = 3'd0,
      MODE_AT_EAST      = 3'd1,
      MODE_LEAVING_EAST = 3'd2,
      MODE_AT_WEST      = 3'd3,
      MODE_LEAVING_WEST = 3'd4,
      MODE_COLLISION    = 3'd5
   } mode_type;

   // bit positions in the seen flags
   localparam int unsigned SEEN_ONE   = 0;
   localparam int unsigned SEEN_TWO   = 1;
   localparam int unsigned SEEN_THREE = 2;
   localparam int unsigned SEEN_FOUR  = 3;

   typedef struct packed {
      direction_type direction;
      logic [3:0]    seen;
      logic          collision;
      mode_type      mode;
      logic          lights;
      logic          gate;
   } state_type;

   // decoded sample: train present per sensor, plus reset request
   typedef struct packed {
      logic t1;
      logic t2;
      logic t3;
      logic t4;
      logic rst;
   } sample_type;

   localparam state_type STATE_RESET = '{
      direction: DIR_NONE,
      seen:      4'b0000,
      collision: 1'b0,
      mode:      MODE_IDLE,
      lights:    1'b0,
      gate:      1'b0
   };

endpackage

`default_nettype wire

// File: sv/lcsc_step.sv
// ----------------------------------------------------------------------------
// lcsc_step - next-state logic for one sensor sample
// Reset request ends a collision; else east, west, then opposite-train check.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsc_step (
   input  var lcsc_pkg::state_type  state_cur,
   input  var lcsc_pkg::sample_type sample,
   output lcsc_pkg::state_type      state_nxt
);

   lcsc_pkg::state_type st;

   always_comb begin
      st = state_cur;
      if (sample.rst && state_cur.collision) begin
         st = lcsc_pkg::STATE_RESET;
      end else if (!state_cur.collision) begin
         // east-to-west chain
         if (st.direction == lcsc_pkg::DIR_NONE && !st.seen[lcsc_pkg::SEEN_ONE] && sample.t1) begin
            st.direction                 = lcsc_pkg::DIR_EAST_TO_WEST;
            st.seen[lcsc_pkg::SEEN_ONE]  = 1'b1;
         end else if (st.direction == lcsc_pkg::DIR_EAST_TO_WEST && st.seen[lcsc_pkg::SEEN_ONE]
                      && !st.seen[lcsc_pkg::SEEN_TWO] && sample.t2) begin
            st.lights                    = 1'b1;
            st.gate                      = 1'b1;
            st.seen[lcsc_pkg::SEEN_TWO]  = 1'b1;
            st.mode                      = lcsc_pkg::MODE_AT_EAST;
         end else if (st.direction == lcsc_pkg::DIR_EAST_TO_WEST && st.seen[lcsc_pkg::SEEN_TWO]
                      && !st.seen[lcsc_pkg::SEEN_THREE] && sample.t3) begin
            st.seen[lcsc_pkg::SEEN_THREE] = 1'b1;
            st.mode                       = lcsc_pkg::MODE_LEAVING_EAST;
         end else if (st.direction == lcsc_pkg::DIR_EAST_TO_WEST && st.seen[lcsc_pkg::SEEN_THREE]
                      && !st.seen[lcsc_pkg::SEEN_FOUR] && sample.t4) begin
            st.lights    = 1'b0;
            st.gate      = 1'b0;
            st.mode      = lcsc_pkg::MODE_IDLE;
            st.direction = lcsc_pkg::DIR_NONE;
            st.seen      = 4'b0000;
         end

         // west-to-east chain, sees the east chain's result
         if (st.direction == lcsc_pkg::DIR_NONE && !st.seen[lcsc_pkg::SEEN_FOUR] && sample.t4) begin
            st.direction                 = lcsc_pkg::DIR_WEST_TO_EAST;
            st.seen[lcsc_pkg::SEEN_FOUR] = 1'b1;
         end else if (st.direction == lcsc_pkg::DIR_WEST_TO_EAST && st.seen[lcsc_pkg::SEEN_FOUR]
                      && !st.seen[lcsc_pkg::SEEN_THREE] && sample.t3) begin
            st.lights                     = 1'b1;
            st.gate                       = 1'b1;
            st.seen[lcsc_pkg::SEEN_THREE] = 1'b1;
            st.mode                       = lcsc_pkg::MODE_AT_WEST;
         end else if (st.direction == lcsc_pkg::DIR_WEST_TO_EAST && st.seen[lcsc_pkg::SEEN_THREE]
                      && !st.seen[lcsc_pkg::SEEN_TWO] && sample.t2) begin
            st.seen[lcsc_pkg::SEEN_TWO] = 1'b1;
            st.mode                     = lcsc_pkg::MODE_LEAVING_WEST;
         end else if (st.direction == lcsc_pkg::DIR_WEST_TO_EAST && st.seen[lcsc_pkg::SEEN_TWO]
                      && !st.seen[lcsc_pkg::SEEN_ONE] && sample.t1) begin
            st.lights    = 1'b0;
            st.gate      = 1'b0;
            st.mode      = lcsc_pkg::MODE_IDLE;
            st.direction = lcsc_pkg::DIR_NONE;
            st.seen      = 4'b0000;
         end

         // opposite-train check
         if ((st.direction == lcsc_pkg::DIR_EAST_TO_WEST && st.seen[lcsc_pkg::SEEN_TWO]
              && !st.seen[lcsc_pkg::SEEN_THREE] && sample.t4) ||
             (st.direction == lcsc_pkg::DIR_WEST_TO_EAST && st.seen[lcsc_pkg::SEEN_THREE]
              && !st.seen[lcsc_pkg::SEEN_TWO] && sample.t1)) begin
            st.mode      = lcsc_pkg::MODE_COLLISION;
            st.lights    = 1'b1;
            st.gate      = 1'b1;
            st.collision = 1'b1;
         end
      end
      state_nxt = st;
   end

endmodule

`default_nettype wire

// File: sv/level_crossing_sequence_controller_top.sv
// ----------------------------------------------------------------------------
// level_crossing_sequence_controller_top - railway level crossing sequencer
// Tracks trains over four sensors, drives lights and gate, latches collisions.
// ----------------------------------------------------------------------------
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+-----------------
//   request | req_sensor_one..four, req_reset_request | req_valid/ready
//   result  | rsp_crossing_state, rsp_warning_lights_ | rsp_valid/ready
//           | on, rsp_gate_lowered, rsp_collision_    |
//           | latched                                 |
//
// One transaction per cycle unless the result stalls. The whole update is
// one pass of flag logic; the state register doubles as the result register,
// so a result appears the cycle after its request transaction is accepted.
// Reset (synchronous) clears the state to idle and empties the result slot.
// A request is taken while the result slot is empty or being drained in the
// same cycle; a stalled result holds the request side off.
// ----------------------------------------------------------------------------
`default_nettype none

module level_crossing_sequence_controller_top (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire        req_sensor_one,
   input  wire        req_sensor_two,
   input  wire        req_sensor_three,
   input  wire        req_sensor_four,
   input  wire        req_reset_request,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [2:0] rsp_crossing_state,
   output logic       rsp_warning_lights_on,
   output logic       rsp_gate_lowered,
   output logic       rsp_collision_latched
);

   lcsc_pkg::state_type  state_ff;
   lcsc_pkg::state_type  state_in;
   lcsc_pkg::sample_type sample;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 req_accept;

   // decode sensor levels: low means a train is present
   assign sample = '{
      t1:  ~req_sensor_one,
      t2:  ~req_sensor_two,
      t3:  ~req_sensor_three,
      t4:  ~req_sensor_four,
      rst: req_reset_request
   };

   // take a new transaction whenever the result slot is empty or frees this cycle
   assign req_ready  = ~rsp_valid_ff | rsp_ready;
   assign req_accept = req_valid & req_ready;

   lcsc_step u_step (
      .state_cur (state_ff),
      .sample    (sample),
      .state_nxt (state_in)
   );

   // fill on accept, drain on take
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // advance state only on accepted transactions; hold it otherwise so it
   // also serves as the stalled result payload
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcsc_pkg::STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            state_ff <= state_in;
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_crossing_state    = state_ff.mode;
   assign rsp_warning_lights_on = state_ff.lights;
   assign rsp_gate_lowered      = state_ff.gate;
   assign rsp_collision_latched = state_ff.collision;

   // a latched collision always reports the collision state
   a_collision_mode : assert property (@(posedge clock) disable iff (reset)
      state_ff.collision |-> state_ff.mode == lcsc_pkg::MODE_COLLISION)
      else $error("collision latched without collision state");

   // lights and gate always move together
   a_lights_gate : assert property (@(posedge clock) disable iff (reset)
      state_ff.lights == state_ff.gate)
      else $error("warning lights and gate disagree");

   // latched collision freezes the state unless a reset request arrives
   a_frozen : assert property (@(posedge clock) disable iff (reset)
      req_accept && state_ff.collision && !req_reset_request |=> $stable(state_ff))
      else $error("state moved while collision latched");

   // every accepted transaction leaves a result waiting
   a_result : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("accepted transaction produced no result");

endmodule

`default_nettype wire
